@@ sv/lzss_pkg.sv @@
package lzss_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int PROD_W       = 32;
    localparam int COPY_W       = 5;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_BADREF = 2'd1;
    localparam logic [1:0] KIND_LIMIT  = 2'd2;

    // output source select
    localparam logic [1:0] SEL_IN     = 2'd0;
    localparam logic [1:0] SEL_MEM    = 2'd1;
    localparam logic [1:0] SEL_LIMIT  = 2'd2;
    localparam logic [1:0] SEL_BADREF = 2'd3;

    typedef struct packed {
        logic       ready;
        logic       save_tag;
        logic       load_count;
        logic       dec_count;
        logic       copy_start;
        logic       copy_step;
        logic       out_load;
        logic [1:0] out_sel;
        logic       out_last;
        logic       clear;
    } lzss_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic limit_hit;
        logic dist_bad;
        logic lit_last;
        logic copy_last;
        logic out_free;
    } lzss_sts_t;

endpackage

@@ sv/lzss_ctrl.sv @@
module lzss_ctrl
    import lzss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_end,
    input  lzss_sts_t sts,
    output lzss_cmd_t cmd
);

    localparam logic [2:0] S_TAG    = 3'd0;
    localparam logic [2:0] S_COUNT  = 3'd1;
    localparam logic [2:0] S_LIT    = 3'd2;
    localparam logic [2:0] S_OFFSET = 3'd3;
    localparam logic [2:0] S_COPY   = 3'd4;
    localparam logic [2:0] S_HALT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       end_reg;
    logic       end_next;
    logic       ready;
    logic       accept;

    assign ready  = (state_reg != S_COPY) && sts.out_free;
    assign accept = in_valid && ready;

    always_comb
    begin
        cmd        = '0;
        cmd.ready  = ready;
        state_next = state_reg;
        end_next   = end_reg;
        unique case (state_reg)
            S_COPY:
            begin
                if (sts.out_free)
                begin
                    if (sts.limit_hit)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_LIMIT;
                        cmd.out_last = 1'b1;
                        state_next   = end_reg ? S_TAG : S_HALT;
                        cmd.clear    = end_reg;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_MEM;
                        cmd.out_last = sts.copy_last;
                        if (sts.copy_last)
                        begin
                            state_next = S_TAG;
                            cmd.clear  = end_reg;
                        end
                        else
                        begin
                            cmd.copy_step = 1'b1;
                        end
                    end
                end
            end
            S_HALT:
            begin
                if (accept && in_end)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_TAG;
                end
            end
            S_TAG, S_COUNT, S_LIT, S_OFFSET:
            begin
                if (accept)
                begin
                    if (sts.limit_hit)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_LIMIT;
                        cmd.out_last = 1'b1;
                        state_next   = S_HALT;
                    end
                    else if (state_reg == S_TAG)
                    begin
                        cmd.save_tag = 1'b1;
                        state_next   = sts.in_zero ? S_COUNT : S_OFFSET;
                    end
                    else if (state_reg == S_COUNT)
                    begin
                        cmd.load_count = 1'b1;
                        state_next     = sts.in_zero ? S_TAG : S_LIT;
                    end
                    else if (state_reg == S_LIT)
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.out_sel   = SEL_IN;
                        cmd.out_last  = 1'b1;
                        cmd.dec_count = 1'b1;
                        state_next    = sts.lit_last ? S_TAG : S_LIT;
                    end
                    else if (sts.dist_bad)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_BADREF;
                        cmd.out_last = 1'b1;
                        state_next   = S_HALT;
                    end
                    else
                    begin
                        cmd.copy_start = 1'b1;
                        end_next       = in_end;
                        state_next     = S_COPY;
                    end
                    // end of stream, unless a copy still has to run
                    if (in_end && !cmd.copy_start)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_TAG;
                    end
                end
            end
            default:
            begin
                state_next = S_TAG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TAG;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg   <= end_next;
        end
    end

endmodule

@@ sv/lzss_dpath.sv @@
module lzss_dpath
    import lzss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic [7:0]  in_byte,
    input  lzss_cmd_t   cmd,
    output lzss_sts_t   sts,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic [1:0]  out_kind,
    output logic        out_last
);

    logic [7:0]        hist_mem [WINDOW_DEPTH];
    logic [7:0]        rd_data_reg;

    logic [PROD_W-1:0] limit_reg;
    logic [PROD_W-1:0] produced_reg;
    logic [PROD_W-1:0] produced_next;
    logic [7:0]        tag_reg;
    logic [7:0]        lit_left_reg;
    logic [7:0]        lit_left_next;
    logic [COPY_W-1:0] copy_left_reg;
    logic [COPY_W-1:0] copy_left_next;
    logic [WIN_AW-1:0] dist_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [1:0]        out_kind_reg;
    logic              out_last_reg;

    logic [WIN_AW-1:0] dist_in;
    logic [WIN_AW-1:0] wr_addr;
    logic [WIN_AW-1:0] rd_addr;
    logic              hist_we;
    logic              hist_re;
    logic [7:0]        data_byte;
    logic              is_data;

    assign dist_in   = {tag_reg[3:0], in_byte};
    assign wr_addr   = produced_reg[WIN_AW-1:0];
    assign is_data   = (cmd.out_sel == SEL_IN) || (cmd.out_sel == SEL_MEM);
    assign hist_we   = cmd.out_load && is_data;
    assign hist_re   = cmd.copy_start || cmd.copy_step;
    assign data_byte = (cmd.out_sel == SEL_MEM) ? rd_data_reg : in_byte;

    // on a step the count moves on by one in the same cycle
    assign rd_addr = cmd.copy_start ? (wr_addr - dist_in)
                                    : (wr_addr + WIN_AW'(1) - dist_reg);

    assign sts.in_zero   = (in_byte == 8'd0);
    assign sts.limit_hit = (produced_reg >= limit_reg);
    assign sts.dist_bad  = (dist_in == '0)
                        || ({{(PROD_W-WIN_AW){1'b0}}, dist_in} > produced_reg);
    assign sts.lit_last  = (lit_left_reg <= 8'd1);
    assign sts.copy_last = (copy_left_reg == COPY_W'(1));
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // history ram, write-first bypass for a distance of one
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wr_addr] <= data_byte;
        end
        if (hist_re)
        begin
            rd_data_reg <= (hist_we && (wr_addr == rd_addr)) ? data_byte : hist_mem[rd_addr];
        end
    end

    always_comb
    begin
        produced_next = produced_reg;
        if (cmd.clear)
        begin
            produced_next = '0;
        end
        else if (hist_we)
        begin
            produced_next = produced_reg + PROD_W'(1);
        end

        lit_left_next = lit_left_reg;
        if (cmd.clear)
        begin
            lit_left_next = '0;
        end
        else if (cmd.load_count)
        begin
            lit_left_next = in_byte;
        end
        else if (cmd.dec_count && (lit_left_reg != 8'd0))
        begin
            lit_left_next = lit_left_reg - 8'd1;
        end

        copy_left_next = copy_left_reg;
        if (cmd.copy_start)
        begin
            copy_left_next = {1'b0, tag_reg[7:4]} + COPY_W'(1);
        end
        else if (cmd.out_load && (cmd.out_sel == SEL_MEM))
        begin
            copy_left_next = copy_left_reg - COPY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '1;
            produced_reg  <= '0;
            tag_reg       <= '0;
            lit_left_reg  <= '0;
            copy_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            produced_reg  <= produced_next;
            lit_left_reg  <= lit_left_next;
            copy_left_reg <= copy_left_next;
            if (cmd.clear)
            begin
                tag_reg <= '0;
            end
            else if (cmd.save_tag)
            begin
                tag_reg <= in_byte;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_start)
        begin
            dist_reg <= dist_in;
        end
        if (cmd.out_load)
        begin
            out_byte_reg <= is_data ? data_byte : 8'd0;
            out_last_reg <= cmd.out_last;
            unique case (cmd.out_sel)
                SEL_IN, SEL_MEM: out_kind_reg <= KIND_DATA;
                SEL_LIMIT:       out_kind_reg <= KIND_LIMIT;
                SEL_BADREF:      out_kind_reg <= KIND_BADREF;
                default:         out_kind_reg <= KIND_DATA;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

@@ sv/lzss_nibble_tag_decompressor_top.sv @@
// lzss decompressor with a 4096-byte history. compressed bytes come in one
// item at a time; tag, count, literal and offset bytes are each taken once
// the output register is free, and a literal loads its data item into
// the output register at the edge that takes it. an offset byte that names a
// good back reference starts a copy of 1 to 16 bytes, read one byte a cycle
// from the history ram (one write port, one registered read port) while the
// output is not stalled; the input is stalled until the copy is done. status
// items (bad reference, output limit) carry a zero data byte and always close
// the results of their input item. the history is not cleared at reset: a copy
// only ever reaches bytes written earlier in the same stream, so the block
// is ready straight after reset. the output limit must be written through
// cfg_wr_en and cfg_wr_data only while the block is idle (the block does not
// enforce this); it is kept across streams
module lzss_nibble_tag_decompressor_top
    import lzss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: output limit register
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // compressed input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    // decompressed result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  out_kind,
    output logic        out_last
);

    lzss_cmd_t cmd;
    lzss_sts_t sts;

    // parse sequencer: tag / count / literal / offset / copy / halted
    lzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_end   (in_end),
        .sts      (sts),
        .cmd      (cmd)
    );

    // history ram, counters, limit register and output register
    lzss_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_byte     (in_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .out_kind    (out_kind),
        .out_last    (out_last)
    );

    // the input is held off while the controller sequences a copy or the output register is stalled
    assign in_stall = !cmd.ready;

    // a status item has a zero byte and is always the closing item
    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind != KIND_DATA)) |-> (out_last && (out_byte == 8'd0)))
        else $error("status item without last flag or with nonzero byte");

    // once a copy starts no new item is taken in the next cycle
    a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_start |=> in_stall)
        else $error("input taken while a copy is running");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");

endmodule
